// ----- hdl/mvrp_pkg.sv -----
// Shared constants and types for the moving-average RMS and peak meter.
`default_nettype none

package mvrp_pkg;

    // Tap count is a power of two, TAPS_LOG2 from 1 to 6.
    localparam int TAPS_LOG2   = 4;
    localparam int TAPS        = 1 << TAPS_LOG2;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + TAPS_LOG2;
    localparam int FRAC_SHIFT  = 4;
    localparam int FILT_W      = 20;
    localparam int MAG_W       = 20;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SQSUM_W     = 54;
    localparam int WLEN_W      = 16;
    localparam int SEQ_W       = 32;
    localparam int ROOT_W      = 20;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int UNIT_W      = SREM_W + 2;
    localparam int DIV_STEPS   = SQSUM_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(2048);

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } eng_stat_t;

endpackage

`default_nettype wire

// ----- hdl/moving_average_rms_peak_meter.sv -----
// Top level of the moving-average RMS and peak meter.
//
// Input channel: sample with sample_valid / sample_ready, one item per audio
// sample. Output channel: filtered, rms, peak and seq with report_valid /
// report_ready, one item per completed window of window_length samples.
// cfg_wen / cfg_wdata write window_length; write it only while idle.
//
// A sample that closes no window updates the FIR tap line and running sum on
// acceptance, then is squared and accumulated through the multiplier.
// A sample that closes a window runs the shared compare-and-subtract unit for
// 54 divide steps and 20 root steps, so its report is loaded into the output
// register once the engine is done and the output slot is free, and only
// then can the next sample be accepted; sample_ready stays low meanwhile.
//
// The output register holds a report until it is taken; samples keep being
// accepted during a stall, and only a second report waits for the slot.
// Reset clears the history, accumulators and counters and sets window_length
// to 2048.
`default_nettype none

module moving_average_rms_peak_meter
    import mvrp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [WLEN_W-1:0]          cfg_wdata,
    input  wire logic                       sample_valid,
    output logic                            sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            report_valid,
    input  wire logic                       report_ready,
    output logic signed [FILT_W-1:0]        filtered,
    output logic [ROOT_W-1:0]               rms,
    output logic [MAG_W-1:0]                peak,
    output logic [SEQ_W-1:0]                seq
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_CALC = 4'b0100,
        S_HOLD = 4'b1000
    } top_state_t;

    top_state_t                state_reg,   state_next;
    logic [WLEN_W-1:0]         wlen_reg;
    logic [SQSUM_W-1:0]        sqsum_reg,   sqsum_next;
    logic [MAG_W-1:0]          peak_reg,    peak_next;
    logic [WLEN_W-1:0]         wcount_reg,  wcount_next;
    logic [SEQ_W-1:0]          scount_reg,  scount_next;
    logic signed [FILT_W-1:0]  filt_rep_reg, filt_rep_next;
    logic [MAG_W-1:0]          peak_rep_reg, peak_rep_next;
    logic [SEQ_W-1:0]          seq_rep_reg,  seq_rep_next;
    logic                      rvalid_reg,  rvalid_next;
    logic signed [FILT_W-1:0]  ofilt_reg,   ofilt_next;
    logic [ROOT_W-1:0]         orms_reg,    orms_next;
    logic [MAG_W-1:0]          opeak_reg,   opeak_next;
    logic [SEQ_W-1:0]          oseq_reg,    oseq_next;

    logic signed [FILT_W-1:0]  filt;
    logic [FILT_W:0]           filt_ext;
    logic [FILT_W:0]           mag_ext;
    logic [MAG_W-1:0]          mag;
    logic [SQ_W-1:0]           sq;
    logic [SQSUM_W-1:0]        sqsum_new;
    logic [MAG_W-1:0]          peak_new;
    logic [WLEN_W-1:0]         count_inc;
    logic                      report_hit;
    logic                      accept;
    logic                      eng_start;
    eng_stat_t                 eng_stat;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;

    mvrp_fir u_fir (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .sample   (sample),
        .filtered (filt)
    );

    mvrp_mean_root u_mean_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eng_start),
        .dividend (sqsum_new),
        .divisor  (count_inc),
        .stat     (eng_stat)
    );

    assign filt_ext   = {filt[FILT_W-1], filt};
    assign mag_ext    = filt[FILT_W-1] ? (~filt_ext + 1'b1) : filt_ext;
    assign mag        = mag_ext[MAG_W-1:0];
    assign sq         = mag * mag;
    assign sqsum_new  = sqsum_reg + SQSUM_W'(sq);
    assign peak_new   = (mag > peak_reg) ? mag : peak_reg;
    assign count_inc  = wcount_reg + 1'b1;
    assign report_hit = (count_inc >= wlen_reg);

    always_comb
    begin
        state_next    = state_reg;
        sqsum_next    = sqsum_reg;
        peak_next     = peak_reg;
        wcount_next   = wcount_reg;
        scount_next   = scount_reg;
        filt_rep_next = filt_rep_reg;
        peak_rep_next = peak_rep_reg;
        seq_rep_next  = seq_rep_reg;
        rvalid_next   = rvalid_reg && !report_ready;
        ofilt_next    = ofilt_reg;
        orms_next     = orms_reg;
        opeak_next    = opeak_reg;
        oseq_next     = oseq_reg;
        eng_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                scount_next = scount_reg + 1'b1;
                if (report_hit)
                begin
                    sqsum_next    = '0;
                    peak_next     = '0;
                    wcount_next   = '0;
                    filt_rep_next = filt;
                    peak_rep_next = peak_new;
                    seq_rep_next  = scount_reg + 1'b1;
                    eng_start     = 1'b1;
                    state_next    = S_CALC;
                end
                else
                begin
                    sqsum_next  = sqsum_new;
                    peak_next   = peak_new;
                    wcount_next = count_inc;
                    state_next  = S_IDLE;
                end
            end
            S_CALC:
            begin
                if (eng_stat.done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!rvalid_reg || report_ready)
                begin
                    rvalid_next = 1'b1;
                    ofilt_next  = filt_rep_reg;
                    orms_next   = eng_stat.root;
                    opeak_next  = peak_rep_reg;
                    oseq_next   = seq_rep_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wlen_reg   <= WLEN_RESET;
            sqsum_reg  <= '0;
            peak_reg   <= '0;
            wcount_reg <= '0;
            scount_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sqsum_reg  <= sqsum_next;
            peak_reg   <= peak_next;
            wcount_reg <= wcount_next;
            scount_reg <= scount_next;
            rvalid_reg <= rvalid_next;
            if (cfg_wen)
            begin
                wlen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        filt_rep_reg <= filt_rep_next;
        peak_rep_reg <= peak_rep_next;
        seq_rep_reg  <= seq_rep_next;
        ofilt_reg    <= ofilt_next;
        orms_reg     <= orms_next;
        opeak_reg    <= opeak_next;
        oseq_reg     <= oseq_next;
    end

    assign report_valid = rvalid_reg;
    assign filtered     = ofilt_reg;
    assign rms          = orms_reg;
    assign peak         = opeak_reg;
    assign seq          = oseq_reg;

`ifndef ASSERT_OFF
    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_ACC)
        else $error("accepted item did not reach accumulate step");

    a_hit_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && report_hit) |=> state_reg == S_CALC)
        else $error("window end did not start the mean and root engine");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.done |-> state_reg == S_CALC)
        else $error("engine finished outside the calculate step");

    a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> rms <= peak)
        else $error("rms exceeds peak in report");
`endif

endmodule

`default_nettype wire

// ----- hdl/mvrp_cmpsub.sv -----
// Shared compare-and-subtract unit used by the divide and square-root steps.
`default_nettype none

module mvrp_cmpsub
    import mvrp_pkg::*;
(
    input  wire logic [UNIT_W-1:0] a,
    input  wire logic [UNIT_W-1:0] b,
    output logic                   ge,
    output logic [UNIT_W-1:0]      diff
);

    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

`default_nettype wire

// ----- hdl/mvrp_fir.sv -----
// Moving-average FIR: tap history, running sum and scaled filtered value.
`default_nettype none

module mvrp_fir
    import mvrp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic signed [FILT_W-1:0]        filtered
);

    logic signed [SAMPLE_W-1:0]        hist_reg [TAPS];
    logic signed [SUM_W-1:0]           sum_reg;
    logic signed [SUM_W-1:0]           sum_next;
    logic signed [SUM_W+FRAC_SHIFT-1:0] scaled;

    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(hist_reg[TAPS-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (load)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < TAPS; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    // floor(16 * sum / TAPS), exact for a power-of-two tap count
    assign scaled   = $signed({sum_reg, {FRAC_SHIFT{1'b0}}}) >>> TAPS_LOG2;
    assign filtered = scaled[FILT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/mvrp_mean_root.sv -----
// Iterative mean and root engine: restoring divide then digit-by-digit square root.
`default_nettype none

module mvrp_mean_root
    import mvrp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SQSUM_W-1:0] dividend,
    input  wire logic [WLEN_W-1:0]  divisor,
    output eng_stat_t               stat
);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_DIV  = 4'b0010,
        E_SQRT = 4'b0100,
        E_DONE = 4'b1000
    } eng_state_t;

    eng_state_t              state_reg,  state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [SQSUM_W-1:0]      q_reg,      q_next;
    logic [WLEN_W-1:0]       drem_reg,   drem_next;
    logic [WLEN_W-1:0]       dvs_reg,    dvs_next;
    logic [SREM_W-1:0]       srem_reg,   srem_next;
    logic [ROOT_W-1:0]       root_reg,   root_next;
    logic [UNIT_W-1:0]       unit_a;
    logic [UNIT_W-1:0]       unit_b;
    logic [UNIT_W-1:0]       unit_diff;
    logic                    unit_ge;

    mvrp_cmpsub u_cmpsub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    always_comb
    begin
        unit_a = '0;
        unit_b = '0;
        case (state_reg)
            E_DIV:
            begin
                unit_a = UNIT_W'({drem_reg, q_reg[SQSUM_W-1]});
                unit_b = UNIT_W'(dvs_reg);
            end
            E_SQRT:
            begin
                unit_a = {srem_reg, q_reg[SQ_W-1 -: 2]};
                unit_b = UNIT_W'({root_reg, 2'b01});
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        drem_next  = drem_reg;
        dvs_next   = dvs_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    q_next     = dividend;
                    drem_next  = '0;
                    dvs_next   = divisor;
                    cnt_next   = '0;
                    state_next = E_DIV;
                end
            end
            E_DIV:
            begin
                q_next    = {q_reg[SQSUM_W-2:0], unit_ge};
                drem_next = unit_ge ? unit_diff[WLEN_W-1:0] : unit_a[WLEN_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = E_SQRT;
                end
            end
            E_SQRT:
            begin
                // quotient never exceeds the largest square, so its top bits are clear
                q_next    = {q_reg[SQSUM_W-3:0], 2'b00};
                srem_next = unit_ge ? unit_diff[SREM_W-1:0] : unit_a[SREM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], unit_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = E_DONE;
                end
            end
            E_DONE:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        drem_reg <= drem_next;
        dvs_reg  <= dvs_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign stat.done = (state_reg == E_DONE);
    assign stat.root = root_reg;

endmodule

`default_nettype wire
